// ===== rtl/core/scp_pkg.sv =====
// Shared types and constants for the servo command text parser.
`default_nettype none

package scp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PulseW = 12;
  localparam int unsigned AccW   = 13;
  localparam int unsigned FieldW = 2;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [AccW-1:0]   AccMax      = 13'd8191;
  localparam logic [PulseW-1:0] PulseMinRst = 12'd1000;
  localparam logic [PulseW-1:0] PulseMaxRst = 12'd2000;
  localparam logic [PulseW-1:0] HeldRst     = 12'd1500;

  localparam logic [PhaseW-1:0] PhGap    = 2'd0;
  localparam logic [PhaseW-1:0] PhLead   = 2'd1;
  localparam logic [PhaseW-1:0] PhDigits = 2'd2;
  localparam logic [PhaseW-1:0] PhIgnore = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgPulseMin = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPulseMax = 1'd1;

  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChOpen  = 8'h28;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             last_byte;
  } item_t;

  typedef struct packed {
    logic [PulseW-1:0] throttle_us;
    logic [PulseW-1:0] steering_us;
    logic              throttle_updated;
    logic              steering_updated;
  } result_t;

  typedef struct packed {
    logic [PulseW-1:0] pulse_min;
    logic [PulseW-1:0] pulse_max;
  } limits_t;

endpackage

`default_nettype wire

// ===== rtl/core/scp_in_stage.sv =====
// Input register stage holding one received byte.
`default_nettype none

module scp_in_stage import scp_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  valid_o,
  output item_t item_o,
  input  wire   take_i
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/scp_parser.sv =====
// Per-byte parse state update, field commit and held pulse values.
`default_nettype none

module scp_parser import scp_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     step_i,
  input  item_t   item_i,
  input  limits_t limits_i,
  output logic    res_valid_o,
  output result_t res_o
);

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [AccW-1:0]   acc;
    logic              neg;
    logic              ended;
  } num_t;

  num_t              num_q, num_d;
  logic [FieldW-1:0] field_q, field_d;
  logic [PulseW-1:0] thr_q, thr_d;
  logic [PulseW-1:0] str_q, str_d;
  logic [1:0]        pend_q, pend_d;

  function automatic num_t number_byte(input num_t s, input logic [ByteW-1:0] ch);
    num_t                r;
    logic [AccW+3:0]     prod;
    logic                is_sp;
    logic                skip;
    r     = s;
    skip  = 1'b0;
    is_sp = (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
    prod  = '0;
    if (s.phase == PhLead) begin
      if (is_sp) begin
        skip = 1'b1;
      end else begin
        r.phase = PhDigits;
        if (ch == ChPlus || ch == ChMinus) begin
          r.neg = (ch == ChMinus);
          skip  = 1'b1;
        end
      end
    end
    if (!skip && !r.ended) begin
      if (ch >= ChZero && ch <= ChNine) begin
        prod = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0}
             + {{(AccW){1'b0}}, ch[3:0]};
        r.acc = (prod > {4'b0000, AccMax}) ? AccMax : prod[AccW-1:0];
      end else begin
        r.ended = 1'b1;
      end
    end
    return r;
  endfunction

  num_t              start_num;
  num_t              na;
  logic              commit_tok;
  logic              nul_seen;
  logic              commit;
  logic              val_ok;
  logic [FieldW-1:0] field_inc;
  logic [ByteW-1:0]  c;

  assign c = item_i.rx_byte;

  always_comb begin
    start_num       = '0;
    start_num.phase = PhLead;
    na              = num_q;
    commit_tok      = 1'b0;
    nul_seen        = 1'b0;
    if (num_q.phase != PhIgnore) begin
      if (c == ChNul) begin
        commit_tok = (num_q.phase != PhGap);
        nul_seen   = 1'b1;
      end else if (num_q.phase == PhGap) begin
        if (c != ChComma) begin
          if (field_q == '0) begin
            if (c == ChOpen) begin
              na = start_num;
            end else begin
              na.phase = PhIgnore;
            end
          end else begin
            na = number_byte(start_num, c);
          end
        end
      end else if (c == ChComma) begin
        commit_tok = 1'b1;
      end else begin
        na = number_byte(num_q, c);
      end
    end

    commit = commit_tok || (item_i.last_byte &&
             (na.phase == PhLead || na.phase == PhDigits));
    val_ok = !(na.neg && na.acc != '0)
           && na.acc >= {1'b0, limits_i.pulse_min}
           && na.acc <= {1'b0, limits_i.pulse_max};
    field_inc = field_q + 1'b1;

    num_d   = na;
    field_d = field_q;
    thr_d   = thr_q;
    str_d   = str_q;
    pend_d  = pend_q;
    if (commit) begin
      field_d   = field_inc;
      num_d.phase = (field_inc >= 2'd2) ? PhIgnore : PhGap;
      if (val_ok && field_q == 2'd0) begin
        thr_d     = na.acc[PulseW-1:0];
        pend_d[0] = 1'b1;
      end
      if (val_ok && field_q == 2'd1) begin
        str_d     = na.acc[PulseW-1:0];
        pend_d[1] = 1'b1;
      end
    end
    if (nul_seen) begin
      num_d.phase = PhIgnore;
    end

    res_o.throttle_us      = thr_d;
    res_o.steering_us      = str_d;
    res_o.throttle_updated = pend_d[0];
    res_o.steering_updated = pend_d[1];

    if (item_i.last_byte) begin
      num_d   = '0;
      num_d.phase = PhGap;
      field_d = '0;
      pend_d  = '0;
    end
  end

  assign res_valid_o = step_i && item_i.last_byte;

  // PhGap is the all-zero phase code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= '0;
      field_q     <= '0;
      thr_q       <= HeldRst;
      str_q       <= HeldRst;
      pend_q      <= '0;
    end else if (step_i) begin
      num_q   <= num_d;
      field_q <= field_d;
      thr_q   <= thr_d;
      str_q   <= str_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scp_out_stage.sv =====
// Output result register for the master stream side.
`default_nettype none

module scp_out_stage import scp_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     res_valid_i,
  input  result_t res_i,
  output logic    can_take_o,
  output logic    valid_o,
  input  wire     ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_take_o = !valid_q || ready_i;
  assign valid_d    = res_valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/servo_command_text_parser.sv =====
// Top level of the servo command text parser.
// Takes a command message such as "(1500, 1500)" one byte per transfer, with
// tlast on the final byte, and returns one result transfer per message holding
// the throttle and steering pulse widths held after it and two flags telling
// which of them the message set. A byte enters an input register and is parsed
// from it against the stored parse state, so one byte is taken every clock unless
// the output register, which holds the final byte's result, stalls; that stall
// holds back the next message's final byte and the input behind it. The user is
// to write the pulse limits through the config channel (index 0 minimum, index 1
// maximum) only while idle; the block itself does not enforce this.
`default_nettype none

module servo_command_text_parser import scp_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire  [ByteW-1:0]     s_axis_tdata_i,   // [7:0] rx_byte
  input  wire                  s_axis_tlast_i,   // last_byte
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [2*PulseW-1:0]  m_axis_tdata_o,   // [11:0] throttle_us, [23:12] steering_us
  output logic [1:0]           m_axis_tuser_o,   // [0] throttle_updated, [1] steering_updated
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [CfgIdxW-1:0]   cfg_index_i,
  input  wire  [PulseW-1:0]    cfg_data_i
);

  limits_t limits_q;
  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    take;
  logic    out_can_take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.pulse_min <= PulseMinRst;
      limits_q.pulse_max <= PulseMaxRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPulseMin: limits_q.pulse_min <= cfg_data_i;
        CfgPulseMax: limits_q.pulse_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.rx_byte   = s_axis_tdata_i;
  assign in_item.last_byte = s_axis_tlast_i;

  scp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .valid_o    (stage_valid),
    .item_o     (stage_item),
    .take_i     (take)
  );

  assign take = stage_valid && (!stage_item.last_byte || out_can_take);

  scp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .item_i      (stage_item),
    .limits_i    (limits_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  scp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_take_o  (out_can_take),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {out_res.steering_us, out_res.throttle_us};
  assign m_axis_tuser_o = {out_res.steering_updated, out_res.throttle_updated};

endmodule

`default_nettype wire
